// ===== hdl/spwm_pkg.sv =====
`default_nettype none

package spwm_pkg;

	localparam int TIME_W = 16;
	localparam int MI_W = 16;
	localparam int MASK_W = 4;
	localparam int MAX_CH = 4;
	localparam int CH_W = 2;
	localparam int CMP_W = 16;
	localparam int RATE_W = 32;
	localparam int PHASE_W = 32;
	localparam int PERIOD_W = 16;
	localparam int MAG_W = 16;
	localparam int STEP_CNT_W = $clog2(TIME_W);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [MI_W-1:0] mi_t;
	typedef logic [MASK_W-1:0] mask_t;
	typedef logic [CMP_W-1:0] cmp_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PHASE_RATE = 2'd0;
	localparam cfg_idx_t CFG_PERIOD_TICKS = 2'd1;
	localparam cfg_idx_t CFG_MIN_INDEX = 2'd2;

	localparam logic [RATE_W-1:0] RST_PHASE_RATE = 32'd214748;
	localparam logic [PERIOD_W-1:0] RST_PERIOD_TICKS = 16'd500;
	localparam logic [MI_W-1:0] RST_MIN_INDEX = 16'd32;

	localparam mag_t Q15_ONE = 16'h8000;

	localparam logic [63:0] SIN_A = 64'd1686629713;
	localparam logic [63:0] SIN_B = 64'd688904866;
	localparam logic [63:0] SIN_C = 64'd76016977;

	// Polynomial sine of a Q30 angle fraction of a quarter wave, rounded to Q1.15.
	function automatic mag_t sin_q15(input logic [63:0] u);
		logic [63:0] u2;
		logic [63:0] t;
		logic [63:0] s;
		u2 = (u * u) >> 30;
		t = SIN_B - ((u2 * SIN_C) >> 30);
		t = SIN_A - ((u2 * t) >> 30);
		s = (u * t) >> 30;
		s = (s + 64'd16384) >> 15;
		if (s > 64'(Q15_ONE)) begin
			s = 64'(Q15_ONE);
		end
		return s[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/spwm_if.sv =====
`default_nettype none

interface spwm_tick_if import spwm_pkg::*; ();
	logic valid;
	logic ready;
	time_t time_step;
	logic master_en;
	mask_t enable_mask;
	mask_t fault_mask;
	mi_t mi_0;
	mi_t mi_1;
	mi_t mi_2;
	mi_t mi_3;

	modport source(output valid, time_step, master_en, enable_mask, fault_mask,
		mi_0, mi_1, mi_2, mi_3, input ready);
	modport sink(input valid, time_step, master_en, enable_mask, fault_mask,
		mi_0, mi_1, mi_2, mi_3, output ready);
endinterface

interface spwm_result_if import spwm_pkg::*; ();
	logic valid;
	logic ready;
	logic [CH_W-1:0] channel;
	cmp_t cmp_count;
	logic direction;
	logic drive_enable;
	logic last;

	modport source(output valid, channel, cmp_count, direction, drive_enable, last,
		input ready);
	modport sink(input valid, channel, cmp_count, direction, drive_enable, last,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/spwm_sine_rom.sv =====
`default_nettype none

module spwm_sine_rom import spwm_pkg::*; #(
	parameter int ENTRIES = 256,
	localparam int AW = $clog2(ENTRIES + 1)
) (
	input wire logic clk,
	input wire logic [AW-1:0] addr,
	output mag_t data
);

	mag_t tab [(1 << AW)];
	mag_t data_q;

	for (genvar k = 0; k <= ENTRIES; k++) begin : g_entry
		localparam logic [63:0] U = (64'(k) << 30) / ENTRIES;
		assign tab[k] = sin_q15(U);
	end

	for (genvar k = ENTRIES + 1; k < (1 << AW); k++) begin : g_pad
		assign tab[k] = '0;
	end

	always_ff @(posedge clk) begin
		data_q <= tab[addr];
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== hdl/sine_pwm_duty_generator_core.sv =====
// Sinusoidal PWM duty generator.
// A word on the tick channel advances the 32-bit phase by time_step times
// phase_rate, then yields one word per channel on the result channel,
// channel 0 first, with last set on the final channel.
// The phase product is formed bit-serially, one time_step bit per cycle, in
// ST_MUL; the index is then formed in ST_IDX and the quarter-wave table is
// read in ST_ROM. Each channel then uses one shared multiplier in two steps,
// first for the duty in ST_DUTY and then for the compare value in ST_CMP.
// A result waits in the output register while ready is low; the channel
// sequence halts until it is taken, so a new tick is taken at the earliest
// once the final word of the previous one has entered the output register.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while no tick is in work, which the block itself
// does not enforce. Reset clears the phase, loads the default register
// values, clears the result valid and leaves the tick channel ready.
`default_nettype none

module sine_pwm_duty_generator_core import spwm_pkg::*; #(
	parameter int CHANNELS = 4,
	parameter int SINE_ENTRIES = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire cfg_idx_t cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	spwm_tick_if.sink tick,
	spwm_result_if.source result
);

	localparam int IW = $clog2(SINE_ENTRIES + 1);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_IDX = 3'd2;
	localparam logic [2:0] ST_ROM = 3'd3;
	localparam logic [2:0] ST_DUTY = 3'd4;
	localparam logic [2:0] ST_CMP = 3'd5;

	logic [2:0] state_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [CW-1:0] ch_q;

	logic [RATE_W-1:0] rate_q;
	logic [PERIOD_W-1:0] period_q;
	mi_t min_index_q;

	phase_t phase_q;
	logic [RATE_W-1:0] rate_sh_q;
	time_t step_sh_q;

	logic gen_q;
	mask_t ena_q;
	mask_t flt_q;
	mi_t mi_q [MAX_CH];

	logic [IW-1:0] idx_q;
	logic dir_q;
	mag_t mag;
	mag_t duty_q;
	logic on_q;

	logic res_valid_q;
	logic [CH_W-1:0] res_ch_q;
	cmp_t res_cmp_q;
	logic res_dir_q;
	logic res_drv_q;
	logic res_last_q;

	logic accept;
	logic out_free;
	logic [CH_W-1:0] ch_sel;
	mi_t mi_sel;
	logic on_sel;
	mi_t mul_a;
	logic [MAG_W:0] mul_b;
	logic [MI_W+MAG_W:0] mul_p;
	logic [PHASE_W-3+IW:0] q_prod;
	logic [IW-1:0] q_val;
	mag_t duty_sat;
	logic last_ch;

	assign accept = tick.valid && tick.ready;
	assign out_free = !res_valid_q || result.ready;
	assign ch_sel = CH_W'(ch_q);
	assign mi_sel = mi_q[ch_sel];
	assign on_sel = gen_q && ena_q[ch_sel] && !flt_q[ch_sel] && (mi_sel > min_index_q);
	assign last_ch = (ch_q == CW'(CHANNELS - 1));

	assign q_prod = {{IW{1'b0}}, phase_q[PHASE_W-3:0]} * (PHASE_W - 2 + IW)'(SINE_ENTRIES);
	assign q_val = q_prod[PHASE_W-2 +: IW];

	spwm_sine_rom #(
		.ENTRIES(SINE_ENTRIES)
	) u_rom (
		.clk(clk),
		.addr(idx_q),
		.data(mag)
	);

	always_comb begin
		if (state_q == ST_CMP) begin
			mul_a = duty_q;
			mul_b = {1'b0, period_q};
		end else begin
			mul_a = mi_sel;
			mul_b = {1'b0, mag};
		end
	end

	assign mul_p = {{(MAG_W + 1){1'b0}}, mul_a} * {{MI_W{1'b0}}, mul_b};
	assign duty_sat = (mul_p[MI_W+MAG_W:15] > (MI_W + MAG_W - 14)'(Q15_ONE)) ?
		Q15_ONE : mul_p[MAG_W+14:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RST_PHASE_RATE;
			period_q <= RST_PERIOD_TICKS;
			min_index_q <= RST_MIN_INDEX;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PHASE_RATE: rate_q <= cfg_data[RATE_W-1:0];
				CFG_PERIOD_TICKS: period_q <= cfg_data[PERIOD_W-1:0];
				CFG_MIN_INDEX: min_index_q <= cfg_data[MI_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			ch_q <= '0;
			phase_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CMP && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_sh_q[0]) begin
						phase_q <= phase_q + rate_sh_q;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_CNT_W'(TIME_W - 1)) begin
						state_q <= ST_IDX;
					end
				end
				ST_IDX: state_q <= ST_ROM;
				ST_ROM: begin
					ch_q <= '0;
					state_q <= ST_DUTY;
				end
				ST_DUTY: state_q <= ST_CMP;
				ST_CMP: begin
					if (out_free) begin
						if (last_ch) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q <= ch_q + 1'b1;
							state_q <= ST_DUTY;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rate_sh_q <= rate_q;
			step_sh_q <= tick.time_step;
			gen_q <= tick.master_en;
			ena_q <= tick.enable_mask;
			flt_q <= tick.fault_mask;
			mi_q[0] <= tick.mi_0;
			mi_q[1] <= tick.mi_1;
			mi_q[2] <= tick.mi_2;
			mi_q[3] <= tick.mi_3;
		end else if (state_q == ST_MUL) begin
			rate_sh_q <= rate_sh_q << 1;
			step_sh_q <= step_sh_q >> 1;
		end
		if (state_q == ST_IDX) begin
			idx_q <= phase_q[PHASE_W-2] ? (IW'(SINE_ENTRIES) - q_val) : q_val;
			dir_q <= !phase_q[PHASE_W-1];
		end
		if (state_q == ST_DUTY) begin
			duty_q <= duty_sat;
			on_q <= on_sel;
		end
		if (state_q == ST_CMP && out_free) begin
			res_ch_q <= ch_sel;
			res_cmp_q <= on_q ? mul_p[CMP_W+14:15] : '0;
			res_dir_q <= dir_q;
			res_drv_q <= on_q;
			res_last_q <= last_ch;
		end
	end

	assign tick.ready = (state_q == ST_IDLE);
	assign result.valid = res_valid_q;
	assign result.channel = res_ch_q;
	assign result.cmp_count = res_cmp_q;
	assign result.direction = res_dir_q;
	assign result.drive_enable = res_drv_q;
	assign result.last = res_last_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MUL)
		else $error("tick taken without starting the phase product");

	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.last |-> result.channel == CH_W'(CHANNELS - 1))
		else $error("last flag on a channel other than the final one");

	a_off_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.drive_enable |-> result.cmp_count == '0)
		else $error("disabled channel with nonzero compare value");

	a_word_sent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP && out_free |=> result.valid)
		else $error("channel word lost at the output register");

endmodule

`default_nettype wire
